// ----- hw/rtl/slot_table_first_fit_allocator_assert.svh -----
// Assertion macros for the slot table allocator.
`ifndef SLOT_TABLE_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define SLOT_TABLE_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define STA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STA_ASSERT(label, clk, rst_n, prop, msg)
`define STA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/stffa_pkg.sv -----
`default_nettype none
package stffa_pkg;
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CHECK = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_NOMEM = 2'd2
    } t_status;

    localparam logic [0:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [0:0] CFG_HEAP_LIMIT = 1'b1;

    // Allocation granule; the rounding logic relies on a power of two.
    localparam int ALIGN_BYTES = 64;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] request_address;
        logic [31:0] request_size;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_address;
    } t_rsp;
endpackage
`default_nettype wire

// ----- hw/rtl/stffa_ram.sv -----
`default_nettype none
module stffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/slot_table_first_fit_allocator.sv -----
// Slot table first-fit heap allocator.
// Requests enter on i_req_valid / o_req_stall with a t_req beat (opcode,
// address, size); each request yields one t_rsp beat on o_rsp_valid /
// i_rsp_stall. Configuration (heap base, heap end) is written through
// i_cfg_we, i_cfg_index and i_cfg_data; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// Slot bases and lengths live in one synchronous RAM, read one slot a cycle;
// used marks are flip-flops. A free or check walks the table at most once; an
// allocate walks the table once per candidate move. A clear, and an
// allocate rejected before placement, do not walk the table.
// One request is handled at a time; the next is taken while the previous
// result waits in the output register.
// Reset clears all used marks, the heap registers and the handshake state.
// While the receiver stalls, the result holds and at most one further
// request is worked on; it then waits until the output register empties.
`default_nettype none
module slot_table_first_fit_allocator
    import stffa_pkg::*;
#(
    parameter int SLOT_COUNT  = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_req_valid,
    output logic        o_req_stall,
    input  wire t_req   i_req,
    output logic        o_rsp_valid,
    input  wire         i_rsp_stall,
    output t_rsp        o_rsp,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
`include "slot_table_first_fit_allocator_assert.svh"

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [31:0] AMASK = 32'(ALIGN_BYTES - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EVAL = 5'b00100,
        S_DONE = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_heap_base, r_heap_limit;
    logic [SLOT_COUNT-1:0] r_used;
    t_req r_req;
    logic [31:0] r_rsize, r_cand;
    logic r_rwrap;
    logic [CW-1:0] r_idx;
    logic [IW-1:0] free_slot;
    logic have_free, r_hit;
    logic [IW-1:0] r_hit_slot;
    logic [CW-1:0] r_moves;
    logic r_pend;
    logic [IW-1:0] r_ev_idx;
    t_rsp r_rsp;
    logic r_rsp_valid;
    logic [1:0] fin_status;
    logic [31:0] fin_addr;

    logic ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [63:0] ram_wdata, ram_rdata;
    logic [31:0] s_base, s_len, s_end, s_endal;

    stffa_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_base = ram_rdata[63:32];
    assign s_len  = ram_rdata[31:0];
    assign s_end  = s_base + s_len;
    assign s_endal = (s_end + AMASK) & ~AMASK;
    assign ram_raddr = r_idx[IW-1:0];

    logic accept, slot_ok, last, can_move;
    logic [31:0] cand_end;
    assign accept = i_req_valid && !o_req_stall;
    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp = r_rsp;
    assign slot_ok = r_used[r_ev_idx];
    assign cand_end = r_cand + r_rsize;
    assign last = (r_idx == CW'(SLOT_COUNT));
    assign can_move = (r_req.opcode == OP_ALLOC) && (r_moves < CW'(SLOT_COUNT));

    logic hit_now;
    always_comb begin
        hit_now = 1'b0;
        case (r_req.opcode)
            OP_ALLOC: hit_now = slot_ok && (r_cand < s_end) && (cand_end > s_base);
            OP_FREE:  hit_now = slot_ok && (s_base == r_req.request_address);
            default:  hit_now = slot_ok && (r_req.request_address >= s_base)
                        && (r_req.request_size <= s_len)
                        && (r_req.request_address - s_base <= s_len - r_req.request_size);
        endcase
    end

    logic in_heap;
    assign in_heap = (r_req.request_size != 32'd0) && (r_req.request_address >= r_heap_base)
        && (r_req.request_address < r_heap_limit)
        && (r_req.request_size <= r_heap_limit - r_req.request_address);

    always_comb begin
        n_state = r_state;
        ram_we = 1'b0;
        ram_waddr = free_slot;
        ram_wdata = {r_cand, r_rsize};
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_SCAN;
            S_SCAN: n_state = S_EVAL;
            S_EVAL: begin
                if (!r_pend) begin
                    n_state = S_DONE;
                end else if (hit_now) begin
                    if (can_move) n_state = S_SCAN;
                    else n_state = S_DONE;
                end else if (last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_rsp_valid || !i_rsp_stall) n_state = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_OUT && r_req.opcode == OP_ALLOC && fin_status == ST_OK) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        fin_status = ST_OK;
        fin_addr = 32'd0;
        case (r_req.opcode)
            OP_ALLOC: begin
                if (r_req.request_size == 32'd0) fin_status = ST_INVAL;
                else if (r_rwrap || !have_free || r_hit) fin_status = ST_NOMEM;
                else if (r_cand >= r_heap_limit || r_rsize > r_heap_limit - r_cand)
                    fin_status = ST_NOMEM;
                else fin_addr = r_cand;
            end
            OP_FREE:  fin_status = r_hit ? ST_OK : ST_INVAL;
            OP_CHECK: fin_status = (r_hit && in_heap) ? ST_OK : ST_INVAL;
            default:  fin_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_heap_base <= 32'd0;
            r_heap_limit <= 32'd0;
            r_rsp_valid <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HEAP_BASE) r_heap_base <= i_cfg_data;
                else r_heap_limit <= i_cfg_data;
            end
            if (r_rsp_valid && !i_rsp_stall) r_rsp_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req <= i_req;
                        r_rsize <= (i_req.request_size + AMASK) & ~AMASK;
                        r_rwrap <= ((i_req.request_size + AMASK) & ~AMASK) < i_req.request_size;
                        r_cand <= r_heap_base;
                        r_idx <= '0;
                        r_moves <= '0;
                        r_hit <= 1'b0;
                        r_pend <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_ev_idx <= r_idx[IW-1:0];
                    r_idx <= r_idx + 1'b1;
                    r_pend <= (r_req.opcode != OP_CLEAR) && (r_req.opcode != OP_ALLOC
                        || (r_req.request_size != 32'd0 && !r_rwrap && have_free
                            && r_cand < r_heap_limit));
                end
                S_EVAL: begin
                    if (r_pend) begin
                        if (hit_now) begin
                            r_pend <= 1'b0;
                            if (can_move) begin
                                r_cand <= s_endal;
                                r_moves <= r_moves + 1'b1;
                                r_idx <= '0;
                            end else begin
                                r_hit <= 1'b1;
                                r_hit_slot <= r_ev_idx;
                            end
                        end else if (last) begin
                            r_pend <= 1'b0;
                        end else begin
                            r_ev_idx <= r_idx[IW-1:0];
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    r_rsp.status <= fin_status;
                    r_rsp.granted_address <= fin_addr;
                    r_rsp_valid <= 1'b1;
                    if (r_req.opcode == OP_CLEAR) r_used <= '0;
                    else if (r_req.opcode == OP_FREE && r_hit) r_used[r_hit_slot] <= 1'b0;
                    else if (r_req.opcode == OP_ALLOC && fin_status == ST_OK)
                        r_used[free_slot] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Lowest free slot, recomputed from the used marks.
    always_comb begin
        have_free = 1'b0;
        free_slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                have_free = 1'b1;
                free_slot = IW'(i);
            end
        end
    end

    `STA_ASSERT(a_one_rsp, i_clk, i_rst_n, (r_state == S_OUT) |-> (!r_rsp_valid || !i_rsp_stall), "result overwritten")
    `STA_ASSERT(a_idle_free, i_clk, i_rst_n, r_rsp_valid && i_rsp_stall |=> r_rsp_valid, "result dropped")
    `STA_ASSERT(a_moves, i_clk, i_rst_n, r_moves <= CW'(SLOT_COUNT), "move count overrun")
endmodule
`default_nettype wire

// ----- tb/tb_slot_table_first_fit_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

import stffa_pkg::*;

class slot_heap_tracker;
    localparam int NSLOT = 16;
    localparam logic [31:0] ALIGN_MASK = 32'h0000_003F;

    logic [31:0] heap_base;
    logic [31:0] heap_limit;
    logic [31:0] slot_base [NSLOT];
    logic [31:0] slot_length [NSLOT];
    bit          slot_used [NSLOT];
    t_rsp        expected_rsp [$];
    int          failures;
    int          n_granted;
    int          n_nomem;
    int          n_inval;
    int          n_checked;

    function new();
        heap_base = '0;
        heap_limit = '0;
        failures = 0;
        n_granted = 0;
        n_nomem = 0;
        n_inval = 0;
        n_checked = 0;
        clear_slots();
    endfunction

    function void clear_slots();
        for (int i = 0; i < NSLOT; i++) begin
            slot_base[i] = '0;
            slot_length[i] = '0;
            slot_used[i] = 0;
        end
    endfunction

    function void set_config(logic [0:0] idx, logic [31:0] value);
        if (idx == CFG_HEAP_BASE) heap_base = value;
        else heap_limit = value;
    endfunction

    function logic [31:0] round_to_granule(logic [31:0] v);
        logic [31:0] t;
        t = v + ALIGN_MASK;
        return t & ~ALIGN_MASK;
    endfunction

    function t_status place_block(logic [31:0] size, output logic [31:0] granted);
        logic [31:0] rsize;
        logic [31:0] cand;
        logic [31:0] slot_stop;
        logic [31:0] cand_stop;
        int          free_slot;
        int          moves;
        bit          moved;
        granted = '0;
        if (size == 0) return ST_INVAL;
        rsize = round_to_granule(size);
        if (rsize < size) return ST_NOMEM;
        free_slot = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (!slot_used[i]) begin
                free_slot = i;
                break;
            end
        end
        if (free_slot < 0) return ST_NOMEM;
        cand = heap_base;
        moves = 0;
        while (cand < heap_limit) begin
            moved = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!slot_used[i]) continue;
                slot_stop = slot_base[i] + slot_length[i];
                cand_stop = cand + rsize;
                if (cand < slot_stop && cand_stop > slot_base[i]) begin
                    if (moves >= NSLOT) return ST_NOMEM;
                    cand = round_to_granule(slot_stop);
                    moves++;
                    moved = 1;
                    break;
                end
            end
            if (!moved) break;
        end
        if (cand >= heap_limit || rsize > heap_limit - cand) return ST_NOMEM;
        slot_base[free_slot] = cand;
        slot_length[free_slot] = rsize;
        slot_used[free_slot] = 1;
        granted = cand;
        return ST_OK;
    endfunction

    function bit range_held(logic [31:0] addr, logic [31:0] size);
        if (size == 0 || addr < heap_base || addr >= heap_limit || size > heap_limit - addr)
            return 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (slot_used[i] && addr >= slot_base[i] && size <= slot_length[i] &&
                addr - slot_base[i] <= slot_length[i] - size)
                return 1;
        end
        return 0;
    endfunction

    function void note_request(t_req r);
        t_rsp        rsp;
        logic [31:0] granted;
        t_status     st;
        granted = '0;
        st = ST_OK;
        case (t_opcode'(r.opcode))
            OP_ALLOC: st = place_block(r.request_size, granted);
            OP_FREE: begin
                st = ST_INVAL;
                for (int i = 0; i < NSLOT; i++) begin
                    if (slot_used[i] && slot_base[i] == r.request_address) begin
                        slot_used[i] = 0;
                        st = ST_OK;
                        break;
                    end
                end
            end
            OP_CHECK: begin
                st = range_held(r.request_address, r.request_size) ? ST_OK : ST_INVAL;
                n_checked++;
            end
            default: clear_slots();
        endcase
        if (st == ST_NOMEM) n_nomem++;
        if (st == ST_INVAL) n_inval++;
        if (t_opcode'(r.opcode) == OP_ALLOC && st == ST_OK) n_granted++;
        rsp.status = st;
        rsp.granted_address = granted;
        expected_rsp.push_back(rsp);
    endfunction

    function void check_result(t_rsp got);
        t_rsp want;
        if (expected_rsp.size() == 0) begin
            $error("unexpected result beat: status %0d granted_address %h",
                   got.status, got.granted_address);
            failures++;
            return;
        end
        want = expected_rsp.pop_front();
        if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            failures++;
        end
        if (got.granted_address !== want.granted_address) begin
            $error("granted_address expected %h actual %h",
                   want.granted_address, got.granted_address);
            failures++;
        end
    endfunction

    function int pending();
        return expected_rsp.size();
    endfunction

    function bit pick_used(output logic [31:0] base, output logic [31:0] len);
        int idx [$];
        int k;
        base = '0;
        len = '0;
        for (int i = 0; i < NSLOT; i++) if (slot_used[i]) idx.push_back(i);
        if (idx.size() == 0) return 0;
        k = idx[$urandom_range(0, idx.size() - 1)];
        base = slot_base[k];
        len = slot_length[k];
        return 1;
    endfunction
endclass

module tb_slot_table_first_fit_allocator;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_ITEMS = 1750;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_stall;
    t_req        i_req;
    logic        o_rsp_valid;
    logic        i_rsp_stall;
    t_rsp        o_rsp;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    slot_heap_tracker tracker;
    int  cycle_count;
    bit  long_hold;
    int  burst_left;

    slot_table_first_fit_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[slot_table_first_fit_allocator] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) tracker.check_result(o_rsp);
    end

    initial begin
        int phase;
        int mode;
        int hold;
        phase = 0;
        mode = 0;
        hold = 0;
        i_rsp_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold && hold == 0) hold = 400;
            if (hold > 0) begin
                hold--;
                if (hold == 0) long_hold = 0;
                i_rsp_stall <= 1'b1;
            end else begin
                phase++;
                if (phase % 80 == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: i_rsp_stall <= 1'b0;
                    1: i_rsp_stall <= ($urandom_range(0, 1) == 1);
                    2: i_rsp_stall <= (phase % 4 != 0);
                    default: i_rsp_stall <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    task automatic send_beat(t_opcode op, logic [31:0] addr, logic [31:0] size);
        t_req r;
        int   gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        r.opcode = op;
        r.request_address = addr;
        r.request_size = size;
        i_req_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        tracker.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_heap(logic [31:0] base, logic [31:0] stop);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_HEAP_BASE;
        i_cfg_data <= base;
        @(negedge i_clk);
        i_cfg_index <= CFG_HEAP_LIMIT;
        i_cfg_data <= stop;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_config(CFG_HEAP_BASE, base);
        tracker.set_config(CFG_HEAP_LIMIT, stop);
    endtask

    task automatic random_beat();
        logic [31:0] base;
        logic [31:0] len;
        logic [31:0] addr;
        logic [31:0] size;
        int          pick;
        int          span;
        pick = $urandom_range(0, 99);
        addr = $urandom;
        if (pick < 45) begin
            span = $urandom_range(0, 19);
            if (span < 12) size = $urandom_range(1, 512);
            else if (span < 16) size = $urandom_range(1, 4096);
            else if (span < 18) size = $urandom;
            else if (span < 19) size = 0;
            else size = 32'hFFFF_FFC0 + $urandom_range(0, 63);
            send_beat(OP_ALLOC, addr, size);
        end else if (pick < 70) begin
            if ($urandom_range(0, 4) != 0 && tracker.pick_used(base, len)) addr = base;
            send_beat(OP_FREE, addr, $urandom);
        end else if (pick < 96) begin
            size = $urandom;
            if ($urandom_range(0, 3) != 0 && tracker.pick_used(base, len)) begin
                addr = base + $urandom_range(0, len);
                size = $urandom_range(0, len + 2);
            end else if ($urandom_range(0, 1) == 0) begin
                addr = tracker.heap_base + $urandom_range(0, 8192);
                size = $urandom_range(0, 1024);
            end
            send_beat(OP_CHECK, addr, size);
        end else begin
            send_beat(OP_CLEAR, addr, $urandom);
        end
    endtask

    initial begin
        logic [31:0] hb [6];
        logic [31:0] he [6];
        logic [31:0] base;
        logic [31:0] len;
        tracker = new();
        cycle_count = 0;
        long_hold = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_HEAP_BASE;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_beat(OP_ALLOC, 32'h0, 32'd64);
        send_beat(OP_CHECK, 32'h0, 32'd1);
        write_heap(32'h0000_1000, 32'h0000_2000);
        send_beat(OP_ALLOC, 32'hFFFF_FFFF, 32'h0);
        send_beat(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
        send_beat(OP_ALLOC, 32'h0, 32'd1);
        send_beat(OP_ALLOC, 32'h0, 32'd64);
        send_beat(OP_ALLOC, 32'h0, 32'd65);
        send_beat(OP_ALLOC, 32'h0, 32'h8000_0000);
        send_beat(OP_CHECK, 32'h0000_1000, 32'h0);
        send_beat(OP_CHECK, 32'h0000_1000, 32'd64);
        send_beat(OP_CHECK, 32'h0000_1FC0, 32'd128);
        send_beat(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_FREE, 32'h0000_1040, 32'h0);
        send_beat(OP_FREE, 32'h0001_2345, 32'h0);
        send_beat(OP_CLEAR, 32'h0, 32'h0);
        for (int i = 0; i < 17; i++) send_beat(OP_ALLOC, 32'h0, 32'd100);
        send_beat(OP_CLEAR, 32'h0, 32'h0);

        hb[0] = 32'h0000_1000; he[0] = 32'h0000_2000;
        hb[1] = 32'h0;         he[1] = 32'hFFFF_FFFF;
        hb[2] = 32'hFFFF_F000; he[2] = 32'hFFFF_FFFF;
        hb[3] = 32'h0000_3000; he[3] = 32'h0000_1000;
        hb[4] = 32'h0000_0000; he[4] = 32'h0000_0000;
        hb[5] = $urandom & 32'hFFFF_FFC0;
        he[5] = hb[5] + $urandom_range(64, 16384);
        for (int p = 0; p < 6; p++) begin
            write_heap(hb[p], he[p]);
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                if (p == 0 && n == 40) long_hold = 1;
                if (p == 1 && n == 100) drain();
                random_beat();
            end
        end
        write_heap(32'hFFFF_FF00, 32'h0000_0100);
        for (int n = 0; n < 20; n++) random_beat();
        if (tracker.pick_used(base, len)) send_beat(OP_FREE, base, len);

        drain();
        repeat (400) @(posedge i_clk);
        $display("Covered %0d allocations granted, %0d out of memory, %0d invalid,",
                 tracker.n_granted, tracker.n_nomem, tracker.n_inval);
        $display("and %0d range checks over several heap settings.", tracker.n_checked);
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("[slot_table_first_fit_allocator] OK");
        end else begin
            $display("[slot_table_first_fit_allocator] ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/stffa_pkg.sv
hw/rtl/stffa_ram.sv
hw/rtl/slot_table_first_fit_allocator.sv
tb/tb_slot_table_first_fit_allocator.sv
